// ----- rtl/cwt_pkg.sv -----
package cwt_pkg;

  // field widths of the packed word
  localparam int unsigned LENGTH_BITS = 28;
  localparam int unsigned OP_BITS     = 4;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned CHAR_BITS   = 8;
  localparam int unsigned DIGIT_BITS  = 4;

  // number of decimal digits in the largest run length
  function automatic int unsigned dec_digits(int unsigned bits);
    longint unsigned v;
    int unsigned     n;
    v = (longint'(1) << bits) - 1;
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 0) begin
        v = v / 10;
        n++;
      end
    end
    return (n == 0) ? 1 : n;
  endfunction

  localparam int unsigned MAX_DIGITS = dec_digits(LENGTH_BITS);
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

  // divide by ten: q = (x * RECIP) >> RECIP_SHIFT, exact for x below 2**32
  localparam int unsigned RECIP_BITS  = 32;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned PROD_W      = LENGTH_BITS + RECIP_SHIFT;
  localparam logic [RECIP_BITS-1:0] RECIP = 32'hCCCC_CCCD;

  // command queue between front and back
  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_DEPTH = 2 ** QUEUE_AW;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_UNKNOWN = 8'h3F;

  typedef enum logic [OP_BITS-1:0] {
    OP_MATCH  = 4'd0,
    OP_INS    = 4'd1,
    OP_DEL    = 4'd2,
    OP_SKIP   = 4'd3,
    OP_SOFT   = 4'd4,
    OP_HARD   = 4'd5,
    OP_PAD    = 4'd6,
    OP_EQUAL  = 4'd7,
    OP_DIFF   = 4'd8
  } op_e;

  typedef logic [DIGIT_BITS-1:0] digit_t;

  // classified request: run length and resolved letter
  typedef struct packed {
    logic [LENGTH_BITS-1:0] len;
    logic [CHAR_BITS-1:0]   letter;
  } cmd_t;

  function automatic logic [CHAR_BITS-1:0] op_letter(logic [OP_BITS-1:0] code);
    logic [CHAR_BITS-1:0] ch;
    unique case (code)
      OP_MATCH: ch = 8'h4D;  // M
      OP_INS:   ch = 8'h49;  // I
      OP_DEL:   ch = 8'h44;  // D
      OP_SKIP:  ch = 8'h4E;  // N
      OP_SOFT:  ch = 8'h53;  // S
      OP_HARD:  ch = 8'h48;  // H
      OP_PAD:   ch = 8'h50;  // P
      OP_EQUAL: ch = 8'h3D;  // =
      OP_DIFF:  ch = 8'h58;  // X
      default:  ch = CHAR_UNKNOWN;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/cwt_if.sv -----
// word channel into the block
interface cigar_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] cigar_word;

  modport source (output valid, output cigar_word, input ready);
  modport sink   (input valid, input cigar_word, output ready);
endinterface

// character channel out of the block
interface text_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

// ----- rtl/cigar_word_to_text_unit.sv -----
// cigar word to text converter
// word_i takes one packed word per request: bits 3..0 the op code, the bits
// above the run length. text_o returns the run length as decimal ASCII,
// most significant digit first without leading zeros ('0' for a zero
// length), then the operation letter (M I D N S H P = X, '?' otherwise)
// with last set. A word of n digits gives n+1 characters, 2 to 10.
// The front splits the word and looks up the letter into a two-entry queue.
// The back divides the length by ten once per cycle through a reciprocal
// multiplier, then hands the digit set to an emitter that sends one
// character per cycle while text_o.ready is high. Conversion of one word
// overlaps emission of the one before, so sustained throughput is bounded
// by the emitter's one character per cycle. Reset empties the queue and
// drops any word in flight; no state carries from one word to the next.
// When text_o.ready is low the current character holds, the converter
// finishes and waits, the queue fills, and word_i.ready falls once both
// queue entries are taken.
module cigar_word_to_text_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  cigar_in_if.sink   word_i,
  text_out_if.source text_o
);
  import cwt_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t front_cmd;
  cmd_t queue_cmd;

  // split and classify
  cwt_front u_front (
    .word_i   (word_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (front_cmd)
  );

  // decoupling queue
  cwt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .cmd_o   (queue_cmd)
  );

  // decimal conversion and character output
  cwt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .cmd_i     (queue_cmd),
    .pop_o     (q_pop),
    .text_o    (text_o)
  );

endmodule

// ----- rtl/cwt_front.sv -----
module cwt_front (
  cigar_in_if.sink        word_i,
  input  logic            q_full_i,
  output logic            push_o,
  output cwt_pkg::cmd_t   cmd_o
);
  import cwt_pkg::*;

  // accept whenever the queue has room
  assign word_i.ready = !q_full_i;
  assign push_o       = word_i.valid && !q_full_i;

  // split the word and resolve the operation letter
  assign cmd_o.len    = word_i.cigar_word[OP_BITS +: LENGTH_BITS];
  assign cmd_o.letter = op_letter(word_i.cigar_word[OP_BITS-1:0]);

endmodule

// ----- rtl/cwt_fifo.sv -----
module cwt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cwt_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output cwt_pkg::cmd_t cmd_o
);
  import cwt_pkg::*;

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/cwt_back.sv -----
module cwt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  cwt_pkg::cmd_t cmd_i,
  output logic          pop_o,
  text_out_if.source    text_o
);
  import cwt_pkg::*;

  // converter: one digit per cycle, least significant first
  logic                          cv_busy_q, cv_busy_d;
  logic                          cv_done_q, cv_done_d;
  logic [CNT_W-1:0]              cv_cnt_q, cv_cnt_d;
  logic [LENGTH_BITS-1:0]        cv_val_q, cv_val_d;
  logic [CHAR_BITS-1:0]          cv_letter_q, cv_letter_d;
  logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0] cv_digits_q, cv_digits_d;

  // emitter: one character per accepted request, most significant first
  logic                          em_busy_q, em_busy_d;
  logic [CNT_W-1:0]              em_left_q, em_left_d;
  logic [CHAR_BITS-1:0]          em_letter_q, em_letter_d;
  logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0] em_digits_q, em_digits_d;

  logic [PROD_W-1:0]             prod;
  logic [LENGTH_BITS-1:0]        quot;
  logic [DIGIT_BITS-1:0]         q10_low;
  digit_t                        rem;
  logic                          em_free;
  logic                          handoff;
  logic                          cv_load;
  logic                          out_fire;

  // divide by ten through the reciprocal, remainder from the low bits
  assign prod    = PROD_W'(cv_val_q) * PROD_W'(RECIP);
  assign quot    = prod[RECIP_SHIFT +: LENGTH_BITS];
  assign q10_low = DIGIT_BITS'({quot[DIGIT_BITS-4:0], 3'b000}) +
                   DIGIT_BITS'({quot[DIGIT_BITS-2:0], 1'b0});
  assign rem     = cv_val_q[DIGIT_BITS-1:0] - q10_low;

  // handshake between the stages and with the queue
  assign out_fire = text_o.valid && text_o.ready;
  assign em_free  = !em_busy_q || (out_fire && (em_left_q == '0));
  assign handoff  = cv_busy_q && cv_done_q && em_free;
  assign cv_load  = !q_empty_i && (!cv_busy_q || handoff);
  assign pop_o    = cv_load;

  // output drive from the emitter registers
  assign text_o.valid    = em_busy_q;
  assign text_o.last     = (em_left_q == '0);
  assign text_o.out_char = (em_left_q == '0) ? em_letter_q
                                             : (CHAR_ZERO | CHAR_BITS'(em_digits_q[0]));

  // converter next state
  always_comb begin
    cv_busy_d   = cv_busy_q;
    cv_done_d   = cv_done_q;
    cv_cnt_d    = cv_cnt_q;
    cv_val_d    = cv_val_q;
    cv_letter_d = cv_letter_q;
    cv_digits_d = cv_digits_q;
    if (cv_load) begin
      cv_busy_d   = 1'b1;
      cv_done_d   = 1'b0;
      cv_cnt_d    = '0;
      cv_val_d    = cmd_i.len;
      cv_letter_d = cmd_i.letter;
    end else if (handoff) begin
      cv_busy_d = 1'b0;
      cv_done_d = 1'b0;
    end else if (cv_busy_q && !cv_done_q) begin
      cv_digits_d = {cv_digits_q[MAX_DIGITS-2:0], rem};
      cv_cnt_d    = cv_cnt_q + 1'b1;
      cv_val_d    = quot;
      cv_done_d   = (quot == '0);
    end
  end

  // emitter next state
  always_comb begin
    em_busy_d   = em_busy_q;
    em_left_d   = em_left_q;
    em_letter_d = em_letter_q;
    em_digits_d = em_digits_q;
    if (handoff) begin
      em_busy_d   = 1'b1;
      em_left_d   = cv_cnt_q;
      em_letter_d = cv_letter_q;
      em_digits_d = cv_digits_q;
    end else if (out_fire) begin
      if (em_left_q == '0) begin
        em_busy_d = 1'b0;
      end else begin
        em_left_d   = em_left_q - 1'b1;
        em_digits_d = {DIGIT_BITS'(0), em_digits_q[MAX_DIGITS-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_busy_q <= 1'b0;
      cv_done_q <= 1'b0;
      cv_cnt_q  <= '0;
      em_busy_q <= 1'b0;
      em_left_q <= '0;
    end else begin
      cv_busy_q <= cv_busy_d;
      cv_done_q <= cv_done_d;
      cv_cnt_q  <= cv_cnt_d;
      em_busy_q <= em_busy_d;
      em_left_q <= em_left_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cv_val_q    <= cv_val_d;
    cv_letter_q <= cv_letter_d;
    cv_digits_q <= cv_digits_d;
    em_letter_q <= em_letter_d;
    em_digits_q <= em_digits_d;
  end

endmodule
